### src/coverage_bitmap_novelty_merge_defines.svh
// ----------------------------------------------------------------------------
// coverage bitmap novelty merge - assertion macros
// shared concurrent assertion wrappers, empty when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef COVERAGE_BITMAP_NOVELTY_MERGE_DEFINES_SVH
`define COVERAGE_BITMAP_NOVELTY_MERGE_DEFINES_SVH

`ifndef SYNTH
// same-cycle implication
`define CBNM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CBNM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CBNM_ASSERT_IMPL(lbl, ante, cons, msg)
`define CBNM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

### src/cbnm_pkg.sv
// ----------------------------------------------------------------------------
// cbnm_pkg
// types, constants and the hit-count classifier shared by the merge block
// ----------------------------------------------------------------------------
package cbnm_pkg;

    localparam int DEF_MAP_ENTRIES = 65536;
    localparam int INDEX_W         = 16;
    localparam int HIT_W           = 8;
    localparam int CLASS_W         = 8;
    localparam int COUNT_W         = 17;
    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_UPDATE
    } cbnm_state_t;

    // controller to datapath
    typedef struct packed {
        logic clear_step;
        logic accept;
        logic update;
    } cbnm_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clear_last;
    } cbnm_status_t;

    // one-hot bucket of a raw hit count
    function automatic logic [CLASS_W-1:0] bucket_of(input logic [HIT_W-1:0] c);
        logic [CLASS_W-1:0] cls;
        priority if (c == 8'd0)   cls = 8'h00;
        else if (c == 8'd1)       cls = 8'h01;
        else if (c == 8'd2)       cls = 8'h02;
        else if (c == 8'd3)       cls = 8'h04;
        else if (c <= 8'd7)       cls = 8'h08;
        else if (c <= 8'd15)      cls = 8'h10;
        else if (c <= 8'd31)      cls = 8'h20;
        else if (c <= 8'd127)     cls = 8'h40;
        else                      cls = 8'h80;
        return cls;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? v : v + COUNT_W'(1);
    endfunction

endpackage

### src/cbnm_ram.sv
// ----------------------------------------------------------------------------
// cbnm_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module cbnm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### src/cbnm_ctrl.sv
// ----------------------------------------------------------------------------
// cbnm_ctrl
// sequencer: clearing sweep after reset, then accept / update per word
// ----------------------------------------------------------------------------
`include "coverage_bitmap_novelty_merge_defines.svh"

module cbnm_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  cbnm_pkg::cbnm_status_t status,
    output cbnm_pkg::cbnm_cmd_t    cmd,
    output logic                  busy
);

    cbnm_pkg::cbnm_state_t state_reg;
    cbnm_pkg::cbnm_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cbnm_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd.clear_step = 1'b0;
        cmd.accept     = 1'b0;
        cmd.update     = 1'b0;
        busy           = 1'b1;
        unique case (state_reg)
            cbnm_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = cbnm_pkg::ST_IDLE;
                end
            end
            cbnm_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.accept = 1'b1;
                    state_next = cbnm_pkg::ST_UPDATE;
                end
            end
            cbnm_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = cbnm_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cbnm_pkg::ST_CLEAR;
            end
        endcase
    end

    `CBNM_ASSERT_NEXT(a_update_one_cycle, state_reg == cbnm_pkg::ST_UPDATE, state_reg == cbnm_pkg::ST_IDLE, "update lasted more than one cycle")
    `CBNM_ASSERT_NEXT(a_accept_to_update, cmd.accept, cmd.update, "accepted word not updated next cycle")

endmodule

### src/cbnm_datapath.sv
// ----------------------------------------------------------------------------
// cbnm_datapath
// global map ram, read-modify-write of one entry, pass and edge counters
// ----------------------------------------------------------------------------
`include "coverage_bitmap_novelty_merge_defines.svh"

module cbnm_datapath #(
    parameter int MAP_ENTRIES = cbnm_pkg::DEF_MAP_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  cbnm_pkg::cbnm_cmd_t           cmd,
    output cbnm_pkg::cbnm_status_t        status,
    input  logic                         kind,
    input  logic [cbnm_pkg::INDEX_W-1:0] index,
    input  logic [cbnm_pkg::HIT_W-1:0]   hit_count,
    input  logic                         last,
    output logic                         done,
    output logic                         found_new,
    output logic [cbnm_pkg::COUNT_W-1:0] added_edges,
    output logic [cbnm_pkg::COUNT_W-1:0] map_edges
);

    localparam int ADDR_W = $clog2(MAP_ENTRIES);

    // latched word
    logic                         kind_reg;
    logic                         last_reg;
    logic [cbnm_pkg::HIT_W-1:0]   hit_reg;
    logic [ADDR_W-1:0]            addr_reg;

    logic [ADDR_W-1:0]            clear_addr_reg;
    logic [ADDR_W-1:0]            clear_addr_next;

    logic                         pass_found_reg;
    logic                         pass_found_next;
    logic [cbnm_pkg::COUNT_W-1:0] pass_new_reg;
    logic [cbnm_pkg::COUNT_W-1:0] pass_new_next;
    logic [cbnm_pkg::COUNT_W-1:0] edge_total_reg;
    logic [cbnm_pkg::COUNT_W-1:0] edge_total_next;

    logic                         done_reg;
    logic                         found_new_reg;
    logic [cbnm_pkg::COUNT_W-1:0] added_edges_reg;
    logic [cbnm_pkg::COUNT_W-1:0] map_edges_reg;

    logic [31:0]                  index_ext;
    logic                         in_range;
    logic [ADDR_W-1:0]            rd_addr;
    logic [cbnm_pkg::CLASS_W-1:0] old_cls;
    logic [cbnm_pkg::CLASS_W-1:0] cls;
    logic                         novel;
    logic                         do_merge;
    logic                         fresh;
    logic                         wr_en;
    logic [ADDR_W-1:0]            wr_addr;
    logic [cbnm_pkg::CLASS_W-1:0] wr_data;
    logic                         found_sum;
    logic [cbnm_pkg::COUNT_W-1:0] pass_new_sum;

    assign index_ext = {{(32 - cbnm_pkg::INDEX_W){1'b0}}, index};
    assign in_range  = index_ext < 32'(MAP_ENTRIES);
    assign rd_addr   = index_ext[ADDR_W-1:0];

    cbnm_ram #(
        .WIDTH (cbnm_pkg::CLASS_W),
        .DEPTH (MAP_ENTRIES)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (cmd.accept),
        .rd_addr (rd_addr),
        .rd_data (old_cls)
    );

    assign status.clear_last = clear_addr_reg == ADDR_W'(MAP_ENTRIES - 1);

    always_comb
    begin
        cls      = cbnm_pkg::bucket_of(hit_reg);
        novel    = |(cls & ~old_cls);
        do_merge = kind_reg && (cls != '0);
        fresh    = do_merge && (old_cls == '0);

        wr_en   = cmd.clear_step || (cmd.update && do_merge);
        wr_addr = cmd.clear_step ? clear_addr_reg : addr_reg;
        wr_data = cmd.clear_step ? '0 : (old_cls | cls);

        clear_addr_next = cmd.clear_step ? clear_addr_reg + ADDR_W'(1) : clear_addr_reg;

        found_sum    = pass_found_reg || novel;
        pass_new_sum = fresh ? cbnm_pkg::sat_inc(pass_new_reg) : pass_new_reg;

        pass_found_next = pass_found_reg;
        pass_new_next   = pass_new_reg;
        edge_total_next = edge_total_reg;
        if (cmd.update)
        begin
            edge_total_next = fresh ? cbnm_pkg::sat_inc(edge_total_reg) : edge_total_reg;
            // a pass ends at its last word
            pass_found_next = last_reg ? 1'b0 : found_sum;
            pass_new_next   = last_reg ? '0 : pass_new_sum;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_addr_reg <= '0;
            pass_found_reg <= 1'b0;
            pass_new_reg   <= '0;
            edge_total_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            clear_addr_reg <= clear_addr_next;
            pass_found_reg <= pass_found_next;
            pass_new_reg   <= pass_new_next;
            edge_total_reg <= edge_total_next;
            done_reg       <= cmd.update && last_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            kind_reg <= kind;
            last_reg <= last;
            // out-of-map entries behave as a zero count
            hit_reg  <= in_range ? hit_count : '0;
            addr_reg <= rd_addr;
        end
        if (cmd.update && last_reg)
        begin
            found_new_reg   <= found_sum;
            added_edges_reg <= pass_new_sum;
            map_edges_reg   <= edge_total_next;
        end
    end

    assign done        = done_reg;
    assign found_new   = found_new_reg;
    assign added_edges = added_edges_reg;
    assign map_edges   = map_edges_reg;

    `CBNM_ASSERT_IMPL(a_done_after_last, done_reg, $past(cmd.update && last_reg), "result without a last word")
    `CBNM_ASSERT_NEXT(a_total_monotonic, cmd.update, edge_total_reg >= $past(edge_total_reg), "edge total went down")
    `CBNM_ASSERT_IMPL(a_pass_within_total, done_reg, added_edges_reg <= map_edges_reg, "pass edges exceed total")

endmodule

### src/coverage_bitmap_novelty_merge.sv
// ----------------------------------------------------------------------------
// coverage_bitmap_novelty_merge
// cumulative hit-count class map with per-pass novelty check and merge
// ----------------------------------------------------------------------------
// Each accepted word (start high while busy is low) carries one local-map
// entry: an index and a raw hit count. The count is sorted into a one-hot
// class and tested against the global entry; merge words also OR the class
// in and count entries that turn nonzero. The global entry is read from the
// map ram through its registered read; in the update that follows, the
// entry is tested, written back and the counters updated, and busy is high
// for one cycle after each accepted word. The result of a pass appears for
// exactly one cycle with done high, in the cycle after the update of the
// word marked last; it cannot be held off, so the receiver must take it
// then. After reset the map is cleared by a sweep over all MAP_ENTRIES
// entries, one entry a cycle, with busy held high throughout.
// ----------------------------------------------------------------------------
module coverage_bitmap_novelty_merge #(
    parameter int MAP_ENTRIES = cbnm_pkg::DEF_MAP_ENTRIES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // word input
    input  logic                         start,
    output logic                         busy,
    input  logic                         kind,
    input  logic [cbnm_pkg::INDEX_W-1:0] index,
    input  logic [cbnm_pkg::HIT_W-1:0]   hit_count,
    input  logic                         last,
    // result, one cycle wide
    output logic                         done,
    output logic                         found_new,
    output logic [cbnm_pkg::COUNT_W-1:0] added_edges,
    output logic [cbnm_pkg::COUNT_W-1:0] map_edges
);

    cbnm_pkg::cbnm_cmd_t    cmd;
    cbnm_pkg::cbnm_status_t status;

    // sequencer: clearing sweep, idle, update
    cbnm_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // map ram, read-modify-write and counters
    cbnm_datapath #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .kind        (kind),
        .index       (index),
        .hit_count   (hit_count),
        .last        (last),
        .done        (done),
        .found_new   (found_new),
        .added_edges (added_edges),
        .map_edges   (map_edges)
    );

endmodule

### tb/sv/coverage_bitmap_novelty_merge_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coverage_bitmap_novelty_merge_test
// self-checking bench: a directed table, then random passes mostly over a small
// hot set of entries, each pass result checked against the table or a class-map tracker
// ----------------------------------------------------------------------------
module coverage_bitmap_novelty_merge_test;

    localparam int INDEX_W = cbnm_pkg::INDEX_W;
    localparam int HIT_W   = cbnm_pkg::HIT_W;
    localparam int CLASS_W = cbnm_pkg::CLASS_W;
    localparam int COUNT_W = cbnm_pkg::COUNT_W;

    // word kinds
    localparam bit KIND_CHECK = 1'b0;
    localparam bit KIND_MERGE = 1'b1;

    localparam int MAP_SIZE        = cbnm_pkg::DEF_MAP_ENTRIES;
    localparam int DIRECTED_COUNT  = 21;
    localparam int RANDOM_WORDS    = 1530;
    localparam int HOT_SLOTS       = 48;
    // quiet cycles allowed: covers the clearing sweep over all MAP_SIZE entries after reset
    localparam int STALL_LIMIT     = 4 * MAP_SIZE;
    // room for the last word's update and its result, with margin
    localparam int TAIL_CYCLES     = 8;
    localparam bit [COUNT_W-1:0] COUNT_CEILING = {COUNT_W{1'b1}};

    // one input word
    typedef struct {
        bit                 kind;
        bit [INDEX_W-1:0]   index;
        bit [HIT_W-1:0]     hit;
        bit                 last;
    } word_t;

    // one pass result
    typedef struct {
        bit                 found;
        bit [COUNT_W-1:0]   fresh;
        bit [COUNT_W-1:0]   total;
    } tally_t;

    // directed row: a word, and where obvious the result it must give
    typedef struct {
        bit                 kind;
        bit [INDEX_W-1:0]   index;
        bit [HIT_W-1:0]     hit;
        bit                 last;
        bit                 typed;
        bit                 found;
        bit [COUNT_W-1:0]   fresh;
        bit [COUNT_W-1:0]   total;
    } row_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   start = 1'b0;
    logic                   busy;
    logic                   kind = 1'b0;
    logic [INDEX_W-1:0]     index = '0;
    logic [HIT_W-1:0]       hit_count = '0;
    logic                   last = 1'b0;
    logic                   done;
    logic                   found_new;
    logic [COUNT_W-1:0]     added_edges;
    logic [COUNT_W-1:0]     map_edges;

    // tracker state: class bits seen per entry, the map edge count and the counters of the pass
    bit [CLASS_W-1:0]       class_map [MAP_SIZE];
    bit [COUNT_W-1:0]       edge_count = '0;
    bit [COUNT_W-1:0]       pass_fresh = '0;
    bit                     pass_found = 1'b0;

    // pass results still to come, oldest first
    tally_t                 pass_tallies [$];
    int                     mismatches = 0;
    int                     quiet_cycles = 0;

    row_t                   directed_rows [DIRECTED_COUNT];
    bit [INDEX_W-1:0]       hot_entries [HOT_SLOTS];

    coverage_bitmap_novelty_merge dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .kind        (kind),
        .index       (index),
        .hit_count   (hit_count),
        .last        (last),
        .done        (done),
        .found_new   (found_new),
        .added_edges (added_edges),
        .map_edges   (map_edges)
    );

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // one-hot class of a raw count, by the pattern of its upper bits
    function automatic bit [CLASS_W-1:0] class_of_count(input bit [HIT_W-1:0] c);
        bit [CLASS_W-1:0] cls;
        casez (c)
            8'b0000_0000:                cls = 8'h00;
            8'b0000_0001:                cls = 8'h01;
            8'b0000_0010:                cls = 8'h02;
            8'b0000_0011:                cls = 8'h04;
            8'b0000_01??:                cls = 8'h08;
            8'b0000_1???:                cls = 8'h10;
            8'b0001_????:                cls = 8'h20;
            8'b001?_????, 8'b01??_????:  cls = 8'h40;
            default:                     cls = 8'h80;
        endcase
        return cls;
    endfunction

    function automatic bit [COUNT_W-1:0] bump_count(input bit [COUNT_W-1:0] v);
        return (v == COUNT_CEILING) ? v : v + COUNT_W'(1);
    endfunction

    // apply one accepted word to the tracker; a last word yields the tally
    task automatic track_word(input word_t w, output bit closes, output tally_t t);
        bit [CLASS_W-1:0] cls;
        bit [CLASS_W-1:0] prior;
        cls = (int'(w.index) < MAP_SIZE) ? class_of_count(w.hit) : '0;
        if (cls != '0)
        begin
            // novelty is judged on the entry as it stood before this word
            prior = class_map[w.index];
            if ((cls & ~prior) != '0)
                pass_found = 1'b1;
            if (w.kind == KIND_MERGE)
            begin
                if (prior == '0)
                begin
                    pass_fresh = bump_count(pass_fresh);
                    edge_count = bump_count(edge_count);
                end
                class_map[w.index] = prior | cls;
            end
        end
        closes = w.last;
        t.found = pass_found;
        t.fresh = pass_fresh;
        t.total = edge_count;
        if (w.last)
        begin
            pass_found = 1'b0;
            pass_fresh = '0;
        end
    endtask

    // sender idles for a number of cycles
    task automatic hold_off(input int cycles);
        if (cycles > 0)
        begin
            start <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // sender stops until every pass result has come back
    task automatic drain_results();
        start <= 1'b0;
        while (pass_tallies.size() != 0)
            @(posedge clk);
    endtask

    // present a word and hold it until the block takes it
    task automatic present_word(input word_t w, output bit closes, output tally_t t);
        start     <= 1'b1;
        kind      <= w.kind;
        index     <= w.index;
        hit_count <= w.hit;
        last      <= w.last;
        do
            @(posedge clk);
        while (busy);
        track_word(w, closes, t);
    endtask

    // mostly entries from the hot set, so that later passes meet earlier merges
    function automatic bit [INDEX_W-1:0] draw_index();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            return hot_entries[$urandom_range(0, HOT_SLOTS - 1)];
        else if (pick < 90)
            return INDEX_W'($urandom);
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            2:       return INDEX_W'(1) << $urandom_range(0, INDEX_W - 1);
            default: return ~(INDEX_W'(1) << $urandom_range(0, INDEX_W - 1));
        endcase
    endfunction

    // a class picked evenly, then a count within it; zero now and then
    function automatic bit [HIT_W-1:0] draw_count();
        case ($urandom_range(0, 8))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'd2;
            3:       return 8'd3;
            4:       return 8'($urandom_range(4, 7));
            5:       return 8'($urandom_range(8, 15));
            6:       return 8'($urandom_range(16, 31));
            7:       return 8'($urandom_range(32, 127));
            default: return 8'($urandom_range(128, 255));
        endcase
    endfunction

    // result checker and watchdog
    always @(posedge clk)
    begin
        tally_t want;
        if (rst_n)
        begin
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("coverage_bitmap_novelty_merge regression: fail");
                $finish;
            end
            else if (done)
            begin
                if (pass_tallies.size() == 0)
                begin
                    $display("%0t: result with none outstanding", $time);
                    mismatches = mismatches + 1;
                end
                else
                begin
                    want = pass_tallies.pop_front();
                    if (found_new !== want.found)
                    begin
                        $display("%0t: found_new expected %0d got %0d",
                                 $time, want.found, found_new);
                        mismatches = mismatches + 1;
                    end
                    if (added_edges !== want.fresh)
                    begin
                        $display("%0t: added_edges expected %0d got %0d",
                                 $time, want.fresh, added_edges);
                        mismatches = mismatches + 1;
                    end
                    if (map_edges !== want.total)
                    begin
                        $display("%0t: map_edges expected %0d got %0d",
                                 $time, want.total, map_edges);
                        mismatches = mismatches + 1;
                    end
                end
            end
        end
    end

    // stimulus
    initial
    begin
        word_t          w;
        tally_t         t;
        bit             closes;
        bit             burst;
        int             sent;
        int             span;
        int             mode;
        int             tries;
        bit             in_pass [bit [INDEX_W-1:0]];

        // fields: kind, index, count, last, typed, found_new, added_edges, map_edges
        directed_rows = '{
            // fresh map: first merge makes one edge
            '{KIND_MERGE, 16'h0000, 8'd1,   1'b1, 1'b1, 1'b1, 17'd1, 17'd1},
            // same class again, check only: nothing new
            '{KIND_CHECK, 16'h0000, 8'd1,   1'b1, 1'b1, 1'b0, 17'd0, 17'd1},
            // new class but check only: map untouched
            '{KIND_CHECK, 16'h0000, 8'd2,   1'b1, 1'b1, 1'b1, 17'd0, 17'd1},
            // top entry, top count
            '{KIND_MERGE, 16'hFFFF, 8'd255, 1'b1, 1'b1, 1'b1, 17'd1, 17'd2},
            // zero count still closes the pass
            '{KIND_MERGE, 16'h0005, 8'd0,   1'b1, 1'b1, 1'b0, 17'd0, 17'd2},
            // repeated entry within one pass counts one edge
            '{KIND_MERGE, 16'h0001, 8'd2,   1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h0001, 8'd3,   1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h0001, 8'd2,   1'b1, 1'b1, 1'b1, 17'd1, 17'd3},
            // merge of a class already held finds nothing
            '{KIND_MERGE, 16'h0000, 8'd1,   1'b1, 1'b1, 1'b0, 17'd0, 17'd3},
            // mixed kinds: only the merge word adds an edge
            '{KIND_CHECK, 16'h0002, 8'd4,   1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h0003, 8'd8,   1'b1, 1'b1, 1'b1, 17'd1, 17'd4},
            // class boundaries on one entry
            '{KIND_MERGE, 16'h00AA, 8'd4,   1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h00AA, 8'd7,   1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h00AA, 8'd15,  1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h00AA, 8'd16,  1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h00AA, 8'd31,  1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h00AA, 8'd32,  1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h00AA, 8'd127, 1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'h00AA, 8'd128, 1'b1, 1'b0, 1'b0, 17'd0, 17'd0},
            // zero count mid-pass, then an alternating index pattern
            '{KIND_CHECK, 16'h5555, 8'd0,   1'b0, 1'b0, 1'b0, 17'd0, 17'd0},
            '{KIND_MERGE, 16'hAAAA, 8'd64,  1'b1, 1'b0, 1'b0, 17'd0, 17'd0}
        };
        foreach (hot_entries[i])
            hot_entries[i] = INDEX_W'($urandom);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed table, gaps drawn as in the random part
        foreach (directed_rows[i])
        begin
            w.kind  = directed_rows[i].kind;
            w.index = directed_rows[i].index;
            w.hit   = directed_rows[i].hit;
            w.last  = directed_rows[i].last;
            if (i != 0)
                hold_off($urandom_range(0, 19));
            present_word(w, closes, t);
            if (closes)
            begin
                if (directed_rows[i].typed)
                begin
                    t.found = directed_rows[i].found;
                    t.fresh = directed_rows[i].fresh;
                    t.total = directed_rows[i].total;
                end
                pass_tallies.push_back(t);
            end
        end

        // full stop once before the random part
        drain_results();

        // random passes: mostly short, some long; kinds all merge, all check
        // or mixed; stretches of back-to-back words
        sent = 0;
        while (sent < RANDOM_WORDS)
        begin
            span  = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                                : $urandom_range(1, 16);
            mode  = $urandom_range(0, 99);
            burst = ($urandom_range(0, 3) == 0);
            in_pass.delete();
            if ($urandom_range(0, 29) == 0)
                drain_results();
            for (int k = 0; k < span; k++)
            begin
                // entries mostly once a pass, an odd repeat let through
                w.index = draw_index();
                tries = 0;
                while (in_pass.exists(w.index) && tries < 3 && $urandom_range(0, 9) != 0)
                begin
                    w.index = draw_index();
                    tries++;
                end
                in_pass[w.index] = 1'b1;
                if (mode < 45)
                    w.kind = KIND_MERGE;
                else if (mode < 80)
                    w.kind = KIND_CHECK;
                else
                    w.kind = $urandom_range(0, 1) ? KIND_MERGE : KIND_CHECK;
                w.hit  = draw_count();
                w.last = (k == span - 1);
                if (!burst && $urandom_range(0, 1))
                    hold_off($urandom_range(0, 19));
                present_word(w, closes, t);
                if (closes)
                    pass_tallies.push_back(t);
                sent++;
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0 && pass_tallies.size() == 0)
            $display("coverage_bitmap_novelty_merge regression: pass");
        else
            $display("coverage_bitmap_novelty_merge regression: fail");
        $finish;
    end

endmodule
